// File: design/igfc_pkg.sv
package igfc_pkg;

    // Item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDLE_TICKS = 1'b0;
    localparam logic [7:0] IDLE_TICKS_RESET = 8'd10;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } igfc_in_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [4:0] position;
        logic [5:0] frame_length;
        logic       is_last;
    } igfc_out_t;

endpackage

// File: design/igfc_store.sv
module igfc_store
    import igfc_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]               rdata
);

    logic [7:0] ram_reg [DEPTH];
    logic [7:0] rdata_reg;

    // Write one byte, read one byte with a registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/igfc_regs.sv
module igfc_regs
    import igfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [7:0]            idle_ticks
);

    logic [7:0] idle_ticks_reg;
    logic       sel_idle_ticks;

    // Decode the register index from the word address
    assign sel_idle_ticks = (paddr[APB_ADDR_W-1] == REG_IDLE_TICKS);

    // Update the idle threshold on the access phase of a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_ticks_reg <= IDLE_TICKS_RESET;
        end
        else if (psel && penable && pwrite && sel_idle_ticks)
        begin
            idle_ticks_reg <= pwdata[7:0];
        end
    end

    // Return the register value, zero elsewhere
    assign prdata     = sel_idle_ticks ? APB_DATA_W'(idle_ticks_reg) : '0;
    assign pready     = 1'b1;
    assign idle_ticks = idle_ticks_reg;

endmodule

// File: design/idle_gap_frame_collector_top.sv
// Channel  | Direction | Handshake                   | Beat
// ---------+-----------+-----------------------------+------------------------------------------
// item     | in        | item_valid / item_ready     | kind, rx_byte
// result   | out       | result_valid / result_ready | data_byte, position, frame_length, is_last
// config   | in        | APB psel/penable, pready=1  | idle_ticks at byte address 0
//
// A byte or an idle tick is taken while no flush runs.
// The tick that ends a frame starts a flush of N bytes, read one beat at a time:
// each beat is one read of the store port followed by one load of the result register.
// Item input is held off during a flush; the last beat may still wait while new items enter.
// Reset clears the byte count, the countdown and the flush control and sets idle_ticks to 10;
// the frame store is not cleared, since only entries written since the last flush are read.
module idle_gap_frame_collector_top
    import igfc_pkg::*;
#(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  igfc_in_t              item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output igfc_out_t             result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       countdown_reg, countdown_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] flen_reg, flen_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] pend_idx_reg, pend_idx_next;
    logic             out_valid_reg, out_valid_next;
    igfc_out_t        out_reg, out_next;

    logic [7:0]       idle_ticks;
    logic             item_take;
    logic             mem_we;
    logic             mem_re;
    logic [7:0]       mem_rdata;
    logic             pend_last;

    // Configuration register
    igfc_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .idle_ticks (idle_ticks)
    );

    // Frame store
    igfc_store #(
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (item.rx_byte),
        .re    (mem_re),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    assign item_ready = (state_reg == ST_IDLE);
    assign item_take  = item_valid && item_ready;
    assign mem_we     = item_take && (item.kind == KIND_BYTE)
                        && (count_reg < CNT_W'(BUFFER_DEPTH));
    // Issue a read only when the result register is free by the time the data lands
    assign mem_re     = (state_reg == ST_FLUSH) && !pend_reg
                        && (!out_valid_reg || result_ready) && (rd_idx_reg < flen_reg);
    assign pend_last  = (pend_idx_reg == flen_reg - CNT_W'(1));

    // Sequence bytes, ticks and the flush
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        countdown_next = countdown_reg;
        rd_idx_next    = rd_idx_reg;
        flen_next      = flen_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        // Drain the result register
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    if (item.kind == KIND_BYTE)
                    begin
                        // Store the byte unless full, reload the countdown in any case
                        if (mem_we)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        countdown_next = idle_ticks;
                    end
                    else if (countdown_reg != 8'd0)
                    begin
                        countdown_next = countdown_reg - 8'd1;
                        // Close the frame when the countdown expires on a nonempty store
                        if ((countdown_reg == 8'd1) && (count_reg != '0))
                        begin
                            state_next  = ST_FLUSH;
                            flen_next   = count_reg;
                            rd_idx_next = '0;
                            count_next  = '0;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                // Advance the read pointer
                if (mem_re)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg;
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                end
                // Load the beat that came back from the store
                if (pend_reg)
                begin
                    out_valid_next        = 1'b1;
                    out_next.data_byte    = mem_rdata;
                    out_next.position     = 5'(pend_idx_reg);
                    out_next.frame_length = 6'(flen_reg);
                    out_next.is_last      = pend_last;
                    if (pend_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            countdown_reg <= 8'd0;
            rd_idx_reg    <= '0;
            flen_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            countdown_reg <= countdown_next;
            rd_idx_reg    <= rd_idx_next;
            flen_reg      <= flen_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Returning read data always finds the result register empty
    a_pend_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !out_valid_reg)
        else $error("store data returned while result register busy");

    // Reads are in flight only during a flush
    a_pend_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_FLUSH))
        else $error("store read pending outside a flush");

    // The byte count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(BUFFER_DEPTH))
        else $error("byte count beyond store depth");

    // A flush starts with a cleared byte count and a nonempty frame
    a_flush_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && (state_next == ST_FLUSH)
        |=> (count_reg == '0) && (flen_reg != '0) && (rd_idx_reg == '0))
        else $error("flush started with bad bookkeeping");

    // The read pointer never runs past the frame
    a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> (rd_idx_reg <= flen_reg))
        else $error("flush read pointer past frame length");

endmodule

// File: tb/tb_idle_gap_frame_collector_top.sv
module tb_idle_gap_frame_collector_top;
    import igfc_pkg::*;

    localparam int FRAME_DEPTH = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [APB_ADDR_W-1:0] IDLE_TICKS_ADDR = APB_ADDR_W'(4 * REG_IDLE_TICKS);

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_ready;
    igfc_in_t              item = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    igfc_out_t             result;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Stimulus and expectations
    igfc_in_t  items_to_send[$];
    igfc_out_t frame_bytes_due[$];
    int        items_queued = 0;
    int        items_accepted = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    logic      item_beat_taken = 1'b0;

    // Shadow copy of the collector state
    logic [7:0] frame_copy[FRAME_DEPTH];
    int         copy_count = 0;
    logic [7:0] copy_countdown = '0;
    logic [7:0] idle_ticks_setting = IDLE_TICKS_RESET;

    // Run statistics
    int mismatches = 0;
    int beats_checked = 0;
    int frames_closed = 0;
    int bytes_dropped = 0;
    int cycle_count = 0;

    idle_gap_frame_collector_top #(
        .BUFFER_DEPTH(FRAME_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Advance the shadow frame by one beat and queue any flushed bytes
    function automatic void advance_frame(igfc_in_t beat);
        igfc_out_t flushed;
        if (beat.kind == KIND_BYTE)
        begin
            if (copy_count < FRAME_DEPTH)
            begin
                frame_copy[copy_count] = beat.rx_byte;
                copy_count++;
            end
            else
            begin
                bytes_dropped++;
            end
            copy_countdown = idle_ticks_setting;
        end
        else if (copy_countdown != 0)
        begin
            copy_countdown--;
            if (copy_countdown == 0)
            begin
                for (int k = 0; k < copy_count; k++)
                begin
                    flushed.data_byte = frame_copy[k];
                    flushed.position = 5'(k);
                    flushed.frame_length = 6'(copy_count);
                    flushed.is_last = (k + 1 == copy_count);
                    frame_bytes_due.push_back(flushed);
                end
                if (copy_count != 0)
                begin
                    frames_closed++;
                end
                copy_count = 0;
            end
        end
    endfunction

    task automatic push_item(logic kind, logic [7:0] data);
        igfc_in_t beat;
        beat.kind = kind;
        beat.rx_byte = data;
        items_to_send.push_back(beat);
        items_queued++;
    endtask

    // Queue one frame: bytes with short silences, then enough ticks to close it
    task automatic queue_frame(int n_bytes, int ticks_needed);
        int gap_max;
        gap_max = (ticks_needed - 1 < 4) ? ticks_needed - 1 : 4;
        for (int i = 0; i < n_bytes; i++)
        begin
            push_item(KIND_BYTE, 8'($urandom));
            if (gap_max > 0 && $urandom_range(2) == 0)
            begin
                repeat ($urandom_range(1, gap_max)) push_item(KIND_TICK, 8'($urandom));
            end
        end
        repeat (ticks_needed) push_item(KIND_TICK, 8'($urandom));
        repeat ($urandom_range(2)) push_item(KIND_TICK, 8'($urandom));
    endtask

    // Mostly well-formed frames, some overfilling the store, some raw noise
    task automatic fill_random(int count);
        int first;
        first = items_queued;
        while (items_queued - first < count)
        begin
            if ($urandom_range(7) == 0)
            begin
                repeat ($urandom_range(1, 4)) push_item(1'($urandom_range(1)), 8'($urandom));
            end
            else if ($urandom_range(7) == 0)
            begin
                queue_frame($urandom_range(FRAME_DEPTH + 1, FRAME_DEPTH + 4),
                            idle_ticks_setting);
            end
            else
            begin
                queue_frame($urandom_range(1, 8), idle_ticks_setting);
            end
        end
    endtask

    // Wait until every beat is in and every frame byte is out
    task automatic settle();
        while (items_accepted != items_queued || frame_bytes_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_check(logic [7:0] want);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= IDLE_TICKS_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== APB_DATA_W'(want))
        begin
            $error("idle_ticks readback: expected %0d, got %0d", want, prdata);
            mismatches++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_write(logic [7:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= IDLE_TICKS_ADDR;
        pwdata <= APB_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        idle_ticks_setting = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        reg_check(value);
    endtask

    // Drive item beats and the result stall at the falling edge
    always @(negedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (item_valid && !item_beat_taken)
        begin
            item_valid <= 1'b1;
        end
        else if (rst_n && items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            item <= items_to_send.pop_front();
            item_valid <= 1'b1;
        end
        else
        begin
            item_valid <= 1'b0;
        end
    end

    // Sample both channels at the rising edge
    always @(posedge clk)
    begin
        item_beat_taken <= item_valid && item_ready;
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                advance_frame(item);
                items_accepted++;
            end
            if (result_valid && result_ready)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    $error("result beat with no frame byte pending");
                    mismatches++;
                end
                else
                begin
                    igfc_out_t want;
                    want = frame_bytes_due.pop_front();
                    beats_checked++;
                    if (result.data_byte !== want.data_byte)
                    begin
                        $error("data_byte: expected %0d, got %0d",
                               want.data_byte, result.data_byte);
                        mismatches++;
                    end
                    if (result.position !== want.position)
                    begin
                        $error("position: expected %0d, got %0d",
                               want.position, result.position);
                        mismatches++;
                    end
                    if (result.frame_length !== want.frame_length)
                    begin
                        $error("frame_length: expected %0d, got %0d",
                               want.frame_length, result.frame_length);
                        mismatches++;
                    end
                    if (result.is_last !== want.is_last)
                    begin
                        $error("is_last: expected %0d, got %0d",
                               want.is_last, result.is_last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Abort a run that stops making progress
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $error("run exceeded %0d cycles", CYCLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 14;
        recv_idle_pct = 86;
        reg_check(IDLE_TICKS_RESET);

        // Tick with no countdown running, then a two-byte frame on the reset setting
        push_item(KIND_TICK, 8'h3C);
        push_item(KIND_BYTE, 8'h00);
        push_item(KIND_BYTE, 8'hFF);
        repeat (IDLE_TICKS_RESET) push_item(KIND_TICK, 8'hC3);
        settle();

        // Shortest timeout: a single tick closes the frame
        reg_write(8'd1);
        push_item(KIND_BYTE, 8'hA5);
        push_item(KIND_BYTE, 8'h5A);
        push_item(KIND_BYTE, 8'hC3);
        push_item(KIND_TICK, 8'h00);
        settle();

        // Zero timeout: no countdown runs until a nonzero setting reloads it
        reg_write(8'd0);
        push_item(KIND_BYTE, 8'h11);
        push_item(KIND_TICK, 8'hFF);
        push_item(KIND_BYTE, 8'h22);
        settle();
        reg_write(8'd2);
        push_item(KIND_BYTE, 8'h33);
        push_item(KIND_TICK, 8'h00);
        push_item(KIND_TICK, 8'h00);
        settle();

        // Random frames, slow receiver
        reg_write(8'd3);
        fill_random(75);
        settle();

        // Random frames, slow sender
        send_idle_pct = 86;
        recv_idle_pct = 14;
        reg_write(8'($urandom_range(4, 12)));
        fill_random(75);
        settle();

        // Overfill the store on the longest timeout, then close it on a one-tick timeout
        send_idle_pct = 0;
        recv_idle_pct = 0;
        reg_write(8'd255);
        for (int i = 0; i < FRAME_DEPTH + 2; i++)
        begin
            push_item(KIND_BYTE, 8'($urandom));
        end
        settle();
        reg_write(8'd1);
        push_item(KIND_BYTE, 8'h7E);
        push_item(KIND_TICK, 8'h00);
        settle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d items and %0d result beats in %0d frames,",
                 items_accepted, beats_checked, frames_closed);
        $display("idle_ticks from 0 to 255, %0d bytes dropped at a full store.", bytes_dropped);
        if (mismatches == 0 && frame_bytes_due.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
